/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, defaults and the digit-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  // Default width of the value to convert.
  localparam int unsigned VALUE_BITS_DEF = 31;

  // Radix register.
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned RADIX_MIN   = 2;
  localparam int unsigned RADIX_MAX   = 16;
  localparam int unsigned RADIX_RESET = 2;

  // Digit and character widths.
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;

  // Entries in the queue between the converter and the digit emitter.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // ASCII codes used for digit characters.
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'd87;  // 'a' minus ten

  // Lower-case hex character of one digit.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] digit);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W - DIGIT_W){1'b0}}, digit};
    if (digit < DIGIT_W'(10)) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_A_BIAS + ext;
    end
  endfunction

endpackage : rdc_pkg

`default_nettype wire

/* rtl/rdc_front.sv */
// ----------------------------------------------------------------------------
// Radix digit converter front end
// Accepts a value and converts it bit-serially into a row of digit cells.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_front import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1),
  localparam int unsigned IDX_W  = $clog2(VALUE_BITS),
  localparam int unsigned STEP_W = $clog2(2 * VALUE_BITS)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [RADIX_W-1:0]                   radix_i,
  input  wire logic                                 in_valid_i,
  input  wire logic [VALUE_BITS-1:0]                in_value_i,
  output logic                                      in_ready_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [VALUE_BITS-1:0][DIGIT_W-1:0]        out_digits_o,
  output logic [CNT_W-1:0]                          out_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_DONE = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [VALUE_BITS-1:0]              shift_q;
  logic [STEP_W-1:0]                  step_q;
  logic [VALUE_BITS-1:1]              en_q;
  logic [VALUE_BITS-1:1]              carry_q;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] digit_q;
  logic [CNT_W-1:0]                   ndig_q;

  logic [VALUE_BITS-1:0]              en_w;
  logic [VALUE_BITS-1:0]              cin_w;
  logic [VALUE_BITS-1:0]              cout_w;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] digit_d;
  logic                               accept;
  logic                               last_step;
  logic                               grow;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign last_step = (step_q == STEP_W'(2 * VALUE_BITS - 2));

  // Each cell steps on a skewed wavefront: cell j sees bit b at step b + j.
  always_comb begin
    en_w[0]  = (state_q == ST_CONV) && (step_q < STEP_W'(VALUE_BITS));
    cin_w[0] = en_w[0] && shift_q[VALUE_BITS-1];
    for (int j = 1; j < int'(VALUE_BITS); j++) begin
      en_w[j]  = en_q[j];
      cin_w[j] = carry_q[j];
    end
  end

  // Cell update: digit doubles and adds the carry in, folding at the radix.
  always_comb begin
    logic [RADIX_W-1:0] sum;
    for (int j = 0; j < int'(VALUE_BITS); j++) begin
      sum = {digit_q[j], 1'b0} + {{(RADIX_W - 1){1'b0}}, cin_w[j]};
      if (sum >= radix_i) begin
        digit_d[j] = DIGIT_W'(sum - radix_i);
        cout_w[j]  = en_w[j];
      end else begin
        digit_d[j] = sum[DIGIT_W-1:0];
        cout_w[j]  = 1'b0;
      end
    end
  end

  // Active cells fill in from the bottom, one new cell at most per step.
  assign grow = (ndig_q < CNT_W'(VALUE_BITS)) && cin_w[ndig_q[IDX_W-1:0]];

  // Sequencing of one conversion.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      en_q    <= '0;
      carry_q <= '0;
      ndig_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q  <= '0;
        en_q    <= '0;
        carry_q <= '0;
        ndig_q  <= '0;
      end else if (state_q == ST_CONV) begin
        step_q  <= step_q + STEP_W'(1);
        en_q    <= en_w[VALUE_BITS-2:0];
        carry_q <= cout_w[VALUE_BITS-2:0];
        if (grow) begin
          ndig_q <= ndig_q + CNT_W'(1);
        end
      end
    end
  end

  // Value shift line and digit cells.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      shift_q <= in_value_i;
      digit_q <= '0;
    end else if (state_q == ST_CONV) begin
      shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
      for (int j = 0; j < int'(VALUE_BITS); j++) begin
        if (en_w[j]) begin
          digit_q[j] <= digit_d[j];
        end
      end
    end
  end

  // A zero value still has one digit.
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_DONE);
  assign out_digits_o = digit_q;
  assign out_count_o  = (ndig_q == '0) ? CNT_W'(1) : ndig_q;

endmodule : rdc_front

`default_nettype wire

/* rtl/rdc_fifo.sv */
// ----------------------------------------------------------------------------
// Radix digit converter queue
// Short queue of converted numbers between the front end and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_fifo import rdc_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic [WIDTH-1:0]      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready_o = (fill_q != CNT_W'(DEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule : rdc_fifo

`default_nettype wire

/* rtl/rdc_back.sv */
// ----------------------------------------------------------------------------
// Radix digit converter emitter
// Walks the digits of the oldest queued number, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_back import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1),
  localparam int unsigned IDX_W = $clog2(VALUE_BITS)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 head_valid_i,
  input  wire logic [VALUE_BITS-1:0][DIGIT_W-1:0]   head_digits_i,
  input  wire logic [CNT_W-1:0]                     head_count_i,
  output logic                                      head_pop_o,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [DIGIT_W-1:0]                        digit_value_o,
  output logic [CHAR_W-1:0]                         digit_char_o,
  output logic                                      last_digit_o
);

  logic               busy_q;
  logic [IDX_W-1:0]   idx_q;
  logic               valid_q;
  logic [DIGIT_W-1:0] dval_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic [CNT_W-1:0]   top_idx;
  logic [IDX_W-1:0]   idx_sel;
  logic [DIGIT_W-1:0] digit_sel;
  logic               load;
  logic               at_last;

  // A fresh number starts at its most significant digit.
  assign top_idx   = head_count_i - CNT_W'(1);
  assign idx_sel   = busy_q ? idx_q : top_idx[IDX_W-1:0];
  assign digit_sel = head_digits_i[idx_sel];
  assign at_last   = (idx_sel == '0);
  assign load      = head_valid_i && (!valid_q || pop);
  assign head_pop_o = load && at_last;

  // Digit walk and output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        busy_q  <= !at_last;
        idx_q   <= idx_sel - IDX_W'(1);
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      dval_q <= digit_sel;
      char_q <= hex_char(digit_sel);
      last_q <= at_last;
    end
  end

  assign empty         = !valid_q;
  assign digit_value_o = dval_q;
  assign digit_char_o  = char_q;
  assign last_digit_o  = last_q;

endmodule : rdc_back

`default_nettype wire

/* rtl/radix_digit_converter.sv */
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts an unsigned integer into its digits in a base from 2 to 16.
// ----------------------------------------------------------------------------
// A value pushed into the block is converted into digits of the current
// radix and read back one beat per digit, most significant digit first, each
// beat carrying the digit value, its lower-case ASCII hex character and a
// flag on the least significant digit; zero gives the single digit '0'.
// Conversion runs the value's bits, most significant first, through a row of
// VALUE_BITS digit cells on a skewed wavefront, so the conversion time of one
// number does not depend on its size, and push sees full from the time a
// value is taken until its digits enter the queue. Digits then
// leave at one per cycle while pop is held, from the emitter, which works
// from a two-entry queue, so the converter can take the next value while the
// digits of earlier numbers are still being emitted.
// Radix writes are clamped to 2..16 and should be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter import rdc_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Radix configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [RADIX_W-1:0]    cfg_data_i,
  // Value input queue side
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [VALUE_BITS-1:0] value_i,
  // Digit output queue side
  output logic                       empty,
  input  wire logic                  pop,
  output logic [DIGIT_W-1:0]         digit_value_o,
  output logic [CHAR_W-1:0]          digit_char_o,
  output logic                       last_digit_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned ENT_W = VALUE_BITS * DIGIT_W + CNT_W;

  logic [RADIX_W-1:0]                 radix_q;
  logic                               in_ready;
  logic                               fr_valid;
  logic                               fr_ready;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] fr_digits;
  logic [CNT_W-1:0]                   fr_count;
  logic                               hd_valid;
  logic                               hd_pop;
  logic [ENT_W-1:0]                   hd_data;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] hd_digits;
  logic [CNT_W-1:0]                   hd_count;

  // Radix register with clamping to the supported range.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_W'(RADIX_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data_i < RADIX_W'(RADIX_MIN)) begin
        radix_q <= RADIX_W'(RADIX_MIN);
      end else if (cfg_data_i > RADIX_W'(RADIX_MAX)) begin
        radix_q <= RADIX_W'(RADIX_MAX);
      end else begin
        radix_q <= cfg_data_i;
      end
    end
  end

  // Converter.
  rdc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_q),
    .in_valid_i   (push),
    .in_value_i   (value_i),
    .in_ready_o   (in_ready),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .out_digits_o (fr_digits),
    .out_count_o  (fr_count)
  );

  assign full = !in_ready;

  // Queue of converted numbers.
  rdc_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  ({fr_count, fr_digits}),
    .rd_valid_o (hd_valid),
    .rd_ready_i (hd_pop),
    .rd_data_o  (hd_data)
  );

  assign hd_digits = hd_data[VALUE_BITS*DIGIT_W-1:0];
  assign hd_count  = hd_data[ENT_W-1:VALUE_BITS*DIGIT_W];

  // Digit emitter.
  rdc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (hd_valid),
    .head_digits_i (hd_digits),
    .head_count_i  (hd_count),
    .head_pop_o    (hd_pop),
    .empty         (empty),
    .pop           (pop),
    .digit_value_o (digit_value_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

endmodule : radix_digit_converter

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix digit converter testbench
// Pushes numbers through the converter under several radix settings and
// checks every digit beat against a prediction made at the input.
// ----------------------------------------------------------------------------
// A directed opening covers zero, the largest value, every digit character and
// the clamping of out-of-range radix writes. A random part then runs phases of
// numbers under random radix settings. Both queue sides stall at random, with
// one phase that never stalls. Radix writes happen only once every predicted
// digit has been read back.
// ----------------------------------------------------------------------------

module tb import rdc_pkg::*;;

  localparam int unsigned VALUE_BITS   = VALUE_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned IDLE_PERCENT = 34;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 27;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'd97;

  // One digit beat as the output side carries it.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  glyph;
    logic               last;
  } digit_beat_t;

  // Predicts the digit beats of each accepted number and checks them in order.
  class digit_tracker;
    int unsigned radix_sel;
    int unsigned mismatches;
    digit_beat_t pending[$];

    function new();
      radix_sel  = RADIX_RESET;
      mismatches = 0;
    endfunction

    // The block holds the radix within its legal range.
    function void set_radix(input logic [RADIX_W-1:0] raw);
      if (raw < RADIX_MIN) begin
        radix_sel = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
        radix_sel = RADIX_MAX;
      end else begin
        radix_sel = raw;
      end
    endfunction

    // Divide down to digits, least significant first, then queue them
    // most significant first. Zero still yields one digit.
    function void note_value(input logic [VALUE_BITS-1:0] number);
      logic [DIGIT_W-1:0] digits [VALUE_BITS];
      longint unsigned    quotient;
      int                 count;
      int                 k;
      digit_beat_t        beat;
      quotient = number;
      count    = 0;
      do begin
        digits[count] = DIGIT_W'(quotient % radix_sel);
        quotient      = quotient / radix_sel;
        count++;
      end while (quotient != 0);
      for (k = count - 1; k >= 0; k--) begin
        beat.digit = digits[k];
        if (digits[k] < 10) begin
          beat.glyph = ASCII_ZERO + CHAR_W'(digits[k]);
        end else begin
          beat.glyph = ASCII_LOWER + CHAR_W'(digits[k]) - CHAR_W'(10);
        end
        beat.last = (k == 0);
        pending.push_back(beat);
      end
    endfunction

    function int unsigned pending_count();
      return pending.size();
    endfunction

    // Compare one accepted beat with the oldest predicted one.
    function void check_digit(input logic [DIGIT_W-1:0] digit,
                              input logic [CHAR_W-1:0]  glyph,
                              input logic               last);
      digit_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digit beat: value %0d char %0d last %0b",
                 $time, digit, glyph, last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (digit !== want.digit) begin
        $display("%0t: digit_value expected %0d actual %0d", $time, want.digit, digit);
        mismatches++;
      end
      if (glyph !== want.glyph) begin
        $display("%0t: digit_char expected %0d actual %0d", $time, want.glyph, glyph);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last_digit expected %0b actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [RADIX_W-1:0]     cfg_data_i;
  logic                   push;
  logic                   full;
  logic [VALUE_BITS-1:0]  value_i;
  logic                   empty;
  logic                   pop;
  logic [DIGIT_W-1:0]     digit_value_o;
  logic [CHAR_W-1:0]      digit_char_o;
  logic                   last_digit_o;

  digit_tracker conv;
  bit           steady;
  int unsigned  cycle_count;

  radix_digit_converter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .value_i       (value_i),
    .empty         (empty),
    .pop           (pop),
    .digit_value_o (digit_value_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output side: stall at random except during the steady phase.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Check every digit beat taken from the output side.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      conv.check_digit(digit_value_o, digit_char_o, last_digit_o);
    end
  end

  // Push one number, with random gaps before it. Entered and left at a
  // falling edge.
  task automatic send_value(input logic [VALUE_BITS-1:0] number);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      push    = 1'b0;
      value_i = VALUE_BITS'($urandom);
      @(negedge clk_i);
    end
    push    = 1'b1;
    value_i = number;
    do @(posedge clk_i); while (full);
    conv.note_value(number);
    @(negedge clk_i);
  endtask

  // Write the radix once every predicted digit has come back.
  task automatic write_radix(input logic [RADIX_W-1:0] raw);
    push = 1'b0;
    while (conv.pending_count() != 0) @(negedge clk_i);
    cfg_valid  = 1'b1;
    cfg_data_i = raw;
    do @(posedge clk_i); while (!cfg_ready);
    conv.set_radix(raw);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Random number: full width, small, random length or close to the top.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return VALUE_BITS'($urandom);
      1: return VALUE_BITS'($urandom_range(0, 40));
      2: return VALUE_BITS'($urandom >> $urandom_range(1, 31));
      default: return {VALUE_BITS{1'b1}} - VALUE_BITS'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin
    logic [RADIX_W-1:0] raw;
    int unsigned        phase;
    int unsigned        n;
    conv        = new();
    steady      = 1'b0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data_i  = '0;
    push        = 1'b0;
    value_i     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: base two from reset, zero, one and the extremes.
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value({VALUE_BITS{1'b1}});
    send_value(VALUE_BITS'(32'h4000_0000));
    send_value(VALUE_BITS'(32'h2AAA_AAAA));
    send_value(VALUE_BITS'(32'h5555_5555));
    // Base sixteen reaches every digit character except '8'.
    write_radix(RADIX_W'(16));
    send_value('0);
    send_value(VALUE_BITS'(32'h7FED_CBA9));
    send_value(VALUE_BITS'(32'h7654_3210));
    send_value({VALUE_BITS{1'b1}});
    write_radix(RADIX_W'(10));
    send_value(VALUE_BITS'(9));
    send_value(VALUE_BITS'(10));
    send_value({VALUE_BITS{1'b1}});
    // Writes below and above the legal range clamp.
    write_radix(RADIX_W'(0));
    send_value(VALUE_BITS'(5));
    write_radix(RADIX_W'(1));
    send_value(VALUE_BITS'(3));
    write_radix(RADIX_W'(17));
    send_value(VALUE_BITS'(255));
    write_radix({RADIX_W{1'b1}});
    send_value(VALUE_BITS'(32'h7ABC_DEF0));
    write_radix(RADIX_W'(3));
    send_value({VALUE_BITS{1'b1}});
    send_value('0);
    write_radix(RADIX_W'(7));
    send_value(VALUE_BITS'(48));

    // Random phases, each under its own radix; one phase never stalls.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        raw = RADIX_W'(2);
      end else if (phase == 1) begin
        raw = RADIX_W'(16);
      end else begin
        raw = RADIX_W'($urandom_range(0, 31));
      end
      write_radix(raw);
      steady = (phase == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value());
      end
    end
    steady = 1'b0;

    // Drain, then give the block time to show any stray beat.
    push = 1'b0;
    while (conv.pending_count() != 0) @(negedge clk_i);
    repeat (2 * VALUE_BITS + 8) @(negedge clk_i);
    if (conv.mismatches == 0 && conv.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rdc_pkg.sv
rtl/rdc_front.sv
rtl/rdc_fifo.sv
rtl/rdc_back.sv
rtl/radix_digit_converter.sv
tb/tb.sv
